>>> rtl/core/paired_read_library_statistics_macros.svh
// assertion macros for the paired-read library statistics block
`ifndef PAIRED_READ_LIBRARY_STATISTICS_MACROS_SVH
`define PAIRED_READ_LIBRARY_STATISTICS_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PRLS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("prls assertion failed");
`define PRLS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("prls assertion failed");
`else
`define PRLS_ASSERT_IMP(lbl, ante, cons)
`define PRLS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/prls_pkg.sv
// shared types and constants of the paired-read library statistics block
package prls_pkg;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int POS_W    = 31;
    localparam int REF_W    = 32;
    localparam int LEN_W    = 16;
    localparam int FLAG_W   = 11;
    localparam int SUM_W    = 48;
    localparam int VAL_W    = 64;
    localparam int IDX_W    = 5;
    localparam int DIV_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int IN_W     = 176;
    localparam int OUT_W    = 72;
    localparam int N_COUNTS = 11;
    localparam int N_SUMS   = 8;
    localparam int N_STATS  = 22;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_INSERT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INSERT = 2'd1;

    localparam int C_READS = 0, C_UNMAPPED = 1, C_REFS = 2, C_MAPPED = 3,
                   C_FILTERED = 4, C_CORRECT = 5, C_ORIENT = 6, C_DIST = 7,
                   C_OTHER = 8, C_SINGLE = 9, C_PROPER = 10;
    localparam int S_READS = 0, S_INSERTS = 1, S_PROPER = 2, S_CORRECT = 3,
                   S_ORIENT = 4, S_DIST = 5, S_OTHER = 6, S_SINGLE = 7;

    localparam int F_PROPER = 1, F_UNMAP = 2, F_MUNMAP = 3, F_REV = 4, F_MREV = 5,
                   F_READ1 = 6, F_READ2 = 7, F_SECOND = 8, F_QCFAIL = 9, F_DUP = 10;

    localparam logic [IDX_W-1:0] STAT_COUNT = 5'd19;
    localparam logic [IDX_W-1:0] STAT_MEAN  = 5'd20;
    localparam logic [IDX_W-1:0] STAT_M2    = 5'd21;

    typedef enum logic {
        OP_DIV,
        OP_SQR
    } t_arith_op;

    typedef struct packed {
        logic      start;
        t_arith_op op;
    } t_arith_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_arith_sts;
endpackage

>>> rtl/core/prls_arith.sv
// shared serial unit: restoring divider and shift-add squarer
`include "paired_read_library_statistics_macros.svh"
module prls_arith #(
    parameter int COUNT_WIDTH = prls_pkg::COUNT_WIDTH_DEF,
    parameter int MEAN_W      = 47
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  prls_pkg::t_arith_cmd          i_cmd,
    input  logic [prls_pkg::DIV_W-1:0]    i_dividend,
    input  logic [COUNT_WIDTH-1:0]        i_divisor,
    input  logic [MEAN_W-1:0]             i_sqr_a,
    output prls_pkg::t_arith_sts          o_sts,
    output logic [prls_pkg::DIV_W-1:0]    o_quotient,
    output logic [COUNT_WIDTH-1:0]        o_remainder,
    output logic [2*MEAN_W-1:0]           o_product
);
    import prls_pkg::*;

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]       r_quo;
    logic [COUNT_WIDTH-1:0] r_rem;
    logic [COUNT_WIDTH-1:0] r_div;
    logic [2*MEAN_W-1:0]    r_acc;
    logic [2*MEAN_W-1:0]    r_mcand;
    logic [MEAN_W-1:0]      r_mplier;
    logic [STEP_W-1:0]      r_step;
    t_arith_op              r_op;
    logic                   r_busy;
    logic                   r_done;
    logic [COUNT_WIDTH:0]   w_trial;
    logic [COUNT_WIDTH:0]   w_diff;
    logic                   w_fit;

    always_comb begin
        w_trial = {r_rem, r_quo[DIV_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_fit   = w_trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
            r_op   <= OP_DIV;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start && !r_busy) begin
                r_busy   <= 1'b1;
                r_op     <= i_cmd.op;
                r_quo    <= i_dividend;
                r_rem    <= '0;
                r_div    <= i_divisor;
                r_acc    <= '0;
                r_mcand  <= {{MEAN_W{1'b0}}, i_sqr_a};
                r_mplier <= i_sqr_a;
                r_step   <= (i_cmd.op == OP_DIV) ? STEP_W'(DIV_W - 1) : STEP_W'(MEAN_W - 1);
            end else if (r_busy) begin
                unique case (r_op)
                    OP_DIV: begin
                        r_rem <= w_fit ? w_diff[COUNT_WIDTH-1:0] : w_trial[COUNT_WIDTH-1:0];
                        r_quo <= {r_quo[DIV_W-2:0], w_fit};
                    end
                    OP_SQR: begin
                        if (r_mplier[0]) begin
                            r_acc <= r_acc + r_mcand;
                        end
                        r_mcand  <= {r_mcand[2*MEAN_W-2:0], 1'b0};
                        r_mplier <= {1'b0, r_mplier[MEAN_W-1:1]};
                    end
                    default: ;
                endcase
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    assign o_sts.busy  = r_busy;
    assign o_sts.done  = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_product   = r_acc;

    `PRLS_ASSERT_IMP(a_start_when_idle, i_cmd.start, !r_busy)
    `PRLS_ASSERT_IMP(a_done_clears_busy, r_done, !r_busy)
    `PRLS_ASSERT_NXT(a_start_sets_busy, i_cmd.start, r_busy)
endmodule

>>> rtl/core/paired_read_library_statistics.sv
// top level: record classification, counters and welford sequencer
// Usage: records arrive on the s-side stream, one transfer per alignment record;
// tdata packs flags, ref_id, mate_ref_id, position, mate_position, read_length and
// aligned_length, tlast marks the final record of a library. A record that is not a
// correctly mated first-in-pair insert is accepted in ST_IDLE and counted in ST_CLASS.
// A correct insert runs the welford update on one shared serial unit: a 64-step
// divide of the mean delta, a square of 31+FRAC_BITS steps and a 64-step divide of
// the squared delta; the divide of the squared delta is skipped when the square
// saturates m2, and the first insert only loads the mean and does not use the unit.
// After a record with tlast the block sends 22 statistic transfers on the m-side
// stream, index 0 to 21, tlast on index 21, one per cycle while tready is high;
// a stalled receiver simply holds the current transfer and no record is taken
// until the report is drained. The configuration channel is always ready; the user
// must write it only while idle (the block does not enforce it). Reset (synchronous,
// active low) clears every counter, sum and welford term, sets the current reference
// to none and loads the insert bounds 100 and 1000000. Stats stay after a report.
`include "paired_read_library_statistics_macros.svh"
module paired_read_library_statistics #(
    parameter int FRAC_BITS   = prls_pkg::FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = prls_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // flags, ref_id, mate_ref_id, position, mate_position, read_length, aligned_length
    input  logic [prls_pkg::IN_W-1:0]         i_s_tdata,
    input  logic                              i_s_tlast,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // stat_index, stat_value
    output logic [prls_pkg::OUT_W-1:0]        o_m_tdata,
    output logic                              o_m_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [prls_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [prls_pkg::POS_W-1:0]        i_cfg_data
);
    import prls_pkg::*;

    localparam int MEAN_W = POS_W + FRAC_BITS;
    localparam int PROD_W = 2 * MEAN_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CLASS, ST_DIVM, ST_SQR, ST_DIVS, ST_REPORT
    } t_state;

    t_state                 r_state;
    logic [POS_W-1:0]       r_min;
    logic [POS_W-1:0]       r_max;
    logic [FLAG_W-1:0]      r_flags;
    logic [REF_W-1:0]       r_ref;
    logic [REF_W-1:0]       r_mref;
    logic [POS_W-1:0]       r_pos;
    logic [POS_W-1:0]       r_mpos;
    logic [LEN_W-1:0]       r_rlen;
    logic [LEN_W-1:0]       r_alen;
    logic                   r_last;
    logic [COUNT_WIDTH-1:0] r_cnt [N_COUNTS];
    logic [SUM_W-1:0]       r_sum [N_SUMS];
    logic [REF_W-1:0]       r_curref;
    logic [COUNT_WIDTH-1:0] r_icnt;
    logic [MEAN_W-1:0]      r_mean;
    logic [VAL_W-1:0]       r_m2;
    logic [MEAN_W-1:0]      r_mag;
    logic                   r_neg;
    logic [DIV_W-1:0]       r_div_a;
    t_arith_cmd             r_cmd;
    logic                   r_m_valid;
    logic [IDX_W-1:0]       r_idx;

    logic [COUNT_WIDTH-1:0] n_cnt [N_COUNTS];
    logic [SUM_W-1:0]       n_sum [N_SUMS];
    logic [REF_W-1:0]       n_curref;
    logic                   w_do_wf;
    logic [POS_W-1:0]       w_x;
    logic [MEAN_W-1:0]      w_xf;
    logic signed [33:0]     w_fwd;
    logic signed [33:0]     w_bwd;
    logic signed [33:0]     w_isize;
    logic                   w_first;
    logic                   w_read1;
    logic                   w_pair;
    logic                   w_mate_ok;
    logic                   w_same;
    logic                   w_oriented;
    logic                   w_in_range;
    t_arith_sts             w_sts;
    logic [DIV_W-1:0]       w_quo;
    logic [COUNT_WIDTH-1:0] w_rem;
    logic [PROD_W-1:0]      w_prod;
    logic [DIV_W:0]         w_ceil;
    logic [DIV_W-1:0]       w_incr;
    logic [VAL_W:0]         w_m2_sum;
    logic [VAL_W-1:0]       w_stat;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] s,
                                                 input logic [POS_W-1:0] v);
        logic [SUM_W:0] t;
        t = {1'b0, s} + {{(SUM_W-POS_W+1){1'b0}}, v};
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

    prls_arith #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .MEAN_W      (MEAN_W)
    ) u_arith (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (r_cmd),
        .i_dividend  (r_div_a),
        .i_divisor   (r_icnt),
        .i_sqr_a     (r_mag),
        .o_sts       (w_sts),
        .o_quotient  (w_quo),
        .o_remainder (w_rem),
        .o_product   (w_prod)
    );

    always_comb begin
        logic [POS_W-1:0] alen_w;
        alen_w     = {{(POS_W-LEN_W){1'b0}}, r_alen};
        n_cnt      = r_cnt;
        n_sum      = r_sum;
        n_curref   = r_curref;
        w_do_wf    = 1'b0;
        w_mate_ok  = !r_flags[F_MUNMAP];
        w_same     = r_ref == r_mref;
        w_fwd      = $signed({3'b0, r_mpos}) + $signed({18'b0, r_rlen}) - 34'sd1
                     - $signed({3'b0, r_pos});
        w_bwd      = $signed({3'b0, r_pos}) + $signed({18'b0, r_alen}) - 34'sd1
                     - $signed({3'b0, r_mpos});
        w_read1    = r_flags[F_READ1];
        w_first    = w_read1 ? (r_pos < r_mpos) : !(r_pos > r_mpos);
        w_pair     = (r_flags[F_READ1] || r_flags[F_READ2]) && w_mate_ok && w_same;
        w_isize    = w_first ? w_fwd : w_bwd;
        w_oriented = w_first ? (!r_flags[F_REV] && r_flags[F_MREV])
                             : (r_flags[F_REV] && !r_flags[F_MREV]);
        w_in_range = !w_isize[33] && (w_isize[32:0] >= {2'b0, r_min})
                     && (w_isize[32:0] <= {2'b0, r_max});
        w_x        = w_isize[POS_W-1:0];
        w_xf       = {w_x, {FRAC_BITS{1'b0}}};

        n_cnt[C_READS] = sat_inc(r_cnt[C_READS]);
        if (r_flags[F_UNMAP]) begin
            n_cnt[C_UNMAPPED] = sat_inc(r_cnt[C_UNMAPPED]);
        end else begin
            if (r_ref != r_curref) begin
                n_cnt[C_REFS] = sat_inc(r_cnt[C_REFS]);
                n_curref      = r_ref;
            end
            if (r_flags[F_DUP] || r_flags[F_SECOND] || r_flags[F_QCFAIL]) begin
                n_cnt[C_FILTERED] = sat_inc(r_cnt[C_FILTERED]);
            end else begin
                n_cnt[C_MAPPED] = sat_inc(r_cnt[C_MAPPED]);
                n_sum[S_READS]  = sum_add(r_sum[S_READS], alen_w);
                if (w_pair) begin
                    if (!w_oriented) begin
                        n_cnt[C_ORIENT] = sat_inc(r_cnt[C_ORIENT]);
                        n_sum[S_ORIENT] = sum_add(r_sum[S_ORIENT], alen_w);
                    end else if (w_in_range) begin
                        if (w_read1) begin
                            w_do_wf          = 1'b1;
                            n_sum[S_INSERTS] = sum_add(r_sum[S_INSERTS], w_x);
                        end
                        n_cnt[C_CORRECT] = sat_inc(r_cnt[C_CORRECT]);
                        n_sum[S_CORRECT] = sum_add(r_sum[S_CORRECT], alen_w);
                    end else begin
                        n_cnt[C_DIST] = sat_inc(r_cnt[C_DIST]);
                        n_sum[S_DIST] = sum_add(r_sum[S_DIST], alen_w);
                    end
                end else if (!w_same && w_mate_ok) begin
                    n_cnt[C_OTHER] = sat_inc(r_cnt[C_OTHER]);
                    n_sum[S_OTHER] = sum_add(r_sum[S_OTHER], alen_w);
                end else if (!w_mate_ok) begin
                    n_cnt[C_SINGLE] = sat_inc(r_cnt[C_SINGLE]);
                    n_sum[S_SINGLE] = sum_add(r_sum[S_SINGLE], alen_w);
                end
                if (r_flags[F_PROPER]) begin
                    n_cnt[C_PROPER] = sat_inc(r_cnt[C_PROPER]);
                    n_sum[S_PROPER] = sum_add(r_sum[S_PROPER], alen_w);
                end
            end
        end
    end

    always_comb begin
        w_ceil   = {1'b0, w_quo} + {{DIV_W{1'b0}}, (w_rem != '0)};
        w_incr   = r_div_a - w_ceil[DIV_W-1:0];
        w_m2_sum = {1'b0, r_m2} + {1'b0, w_incr};
    end

    always_comb begin
        if (r_idx < IDX_W'(N_COUNTS)) begin
            w_stat = {{(VAL_W-COUNT_WIDTH){1'b0}}, r_cnt[r_idx[3:0]]};
        end else if (r_idx < STAT_COUNT) begin
            w_stat = {{(VAL_W-SUM_W){1'b0}}, r_sum[3'(r_idx - IDX_W'(N_COUNTS))]};
        end else if (r_idx == STAT_COUNT) begin
            w_stat = {{(VAL_W-COUNT_WIDTH){1'b0}}, r_icnt};
        end else if (r_idx == STAT_MEAN) begin
            w_stat = {{(VAL_W-MEAN_W){1'b0}}, r_mean};
        end else begin
            w_stat = r_m2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_min     <= POS_W'(100);
            r_max     <= POS_W'(1000000);
            r_cnt     <= '{default: '0};
            r_sum     <= '{default: '0};
            r_curref  <= '1;
            r_icnt    <= '0;
            r_mean    <= '0;
            r_m2      <= '0;
            r_cmd     <= '{start: 1'b0, op: OP_DIV};
            r_m_valid <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_MIN_INSERT) begin
                    r_min <= i_cfg_data;
                end else if (i_cfg_index == REG_MAX_INSERT) begin
                    r_max <= i_cfg_data;
                end
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_cmd.start <= 1'b0;
                    if (i_s_tvalid) begin
                        r_flags <= i_s_tdata[10:0];
                        r_ref   <= i_s_tdata[42:11];
                        r_mref  <= i_s_tdata[74:43];
                        r_pos   <= i_s_tdata[105:75];
                        r_mpos  <= i_s_tdata[136:106];
                        r_rlen  <= i_s_tdata[152:137];
                        r_alen  <= i_s_tdata[168:153];
                        r_last  <= i_s_tlast;
                        r_state <= ST_CLASS;
                    end
                end
                ST_CLASS: begin
                    r_cnt    <= n_cnt;
                    r_sum    <= n_sum;
                    r_curref <= n_curref;
                    r_neg    <= w_xf < r_mean;
                    r_mag    <= (w_xf < r_mean) ? r_mean - w_xf : w_xf - r_mean;
                    r_div_a  <= {{(DIV_W-MEAN_W){1'b0}},
                                 (w_xf < r_mean) ? r_mean - w_xf : w_xf - r_mean};
                    if (w_do_wf && r_icnt != '0) begin
                        r_icnt  <= sat_inc(r_icnt);
                        r_cmd   <= '{start: 1'b1, op: OP_DIV};
                        r_state <= ST_DIVM;
                    end else begin
                        r_cmd.start <= 1'b0;
                        if (w_do_wf) begin
                            r_icnt <= COUNT_WIDTH'(1);
                            r_mean <= w_xf;
                            r_m2   <= '0;
                        end
                        r_state   <= r_last ? ST_REPORT : ST_IDLE;
                        r_m_valid <= r_last;
                        r_idx     <= '0;
                    end
                end
                ST_DIVM: begin
                    if (w_sts.done) begin
                        r_mean  <= r_neg ? r_mean - w_quo[MEAN_W-1:0]
                                         : r_mean + w_quo[MEAN_W-1:0];
                        r_cmd   <= '{start: 1'b1, op: OP_SQR};
                        r_state <= ST_SQR;
                    end else begin
                        r_cmd.start <= 1'b0;
                    end
                end
                ST_SQR: begin
                    if (w_sts.done) begin
                        if (|w_prod[PROD_W-1:DIV_W+FRAC_BITS]) begin
                            r_cmd.start <= 1'b0;
                            r_m2        <= '1;
                            r_state     <= r_last ? ST_REPORT : ST_IDLE;
                            r_m_valid   <= r_last;
                            r_idx       <= '0;
                        end else begin
                            r_div_a <= w_prod[DIV_W+FRAC_BITS-1:FRAC_BITS];
                            r_cmd   <= '{start: 1'b1, op: OP_DIV};
                            r_state <= ST_DIVS;
                        end
                    end else begin
                        r_cmd.start <= 1'b0;
                    end
                end
                ST_DIVS: begin
                    r_cmd.start <= 1'b0;
                    if (w_sts.done) begin
                        r_m2      <= w_m2_sum[VAL_W] ? {VAL_W{1'b1}} : w_m2_sum[VAL_W-1:0];
                        r_state   <= r_last ? ST_REPORT : ST_IDLE;
                        r_m_valid <= r_last;
                        r_idx     <= '0;
                    end
                end
                ST_REPORT: begin
                    r_cmd.start <= 1'b0;
                    if (i_m_tready) begin
                        if (r_idx == STAT_M2) begin
                            r_m_valid <= 1'b0;
                            r_state   <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_cmd.start <= 1'b0;
                    r_state     <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tlast   = r_m_valid && (r_idx == STAT_M2);
    assign o_m_tdata   = {{(OUT_W-VAL_W-IDX_W){1'b0}}, w_stat, r_idx};

    `PRLS_ASSERT_IMP(a_report_in_report_state, r_m_valid, r_state == ST_REPORT)
    `PRLS_ASSERT_IMP(a_unit_idle_when_ready, o_s_tready, !w_sts.busy)
    `PRLS_ASSERT_NXT(a_report_end_idle, r_m_valid && i_m_tready && r_idx == STAT_M2,
                     !r_m_valid && r_state == ST_IDLE)
endmodule
